@@ sv/flb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// flb_pkg: shared types and constants
// Command and status bundles between controller and datapath, codes.
// ---------------------------------------------------------------------------
package flb_pkg;

  localparam int DEF_MAX_BACKENDS = 8;
  localparam int DEF_FLOW_ENTRIES = 1024;

  localparam logic [1:0] VERDICT_PASS    = 2'd0;
  localparam logic [1:0] VERDICT_DROP    = 2'd1;
  localparam logic [1:0] VERDICT_FORWARD = 2'd2;
  localparam logic [1:0] VERDICT_ABORT   = 2'd3;

  localparam logic [0:0]  ACTION_SETUP = 1'b1;
  localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [16:0] ETH_BYTES    = 17'd14;
  localparam logic [16:0] IP_MIN_BYTES = 17'd20;
  localparam logic [16:0] UDP_BYTES    = 17'd8;

  localparam int DIV_W = 32;

  typedef struct packed {
    logic load;
    logic check;
    logic scan;
    logic div_start;
    logic bstep;
    logic pick;
    logic commit;
    logic out_load;
  } flb_cmd_t;

  typedef struct packed {
    logic udp;
    logic hit;
    logic miss;
    logic b_more;
    logic div_done;
    logic have;
  } flb_sts_t;

endpackage
`default_nettype wire

@@ sv/flb_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// flb_div: serial unsigned divider
// Restoring division, one quotient bit per cycle; done pulses once.
// ---------------------------------------------------------------------------
module flb_div
  import flb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DIV_W-1:0] divisor,
  output logic                  done,
  output logic [DIV_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] q_r, d_r;
  logic [DIV_W:0]   rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DIV_W:0]   shifted;

  assign shifted  = {rem_r[DIV_W-1:0], q_r[DIV_W-1]};
  assign done     = done_r;
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      d_r   <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      if (shifted >= {1'b0, d_r}) begin
        rem_r <= shifted - {1'b0, d_r};
        q_r   <= {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted;
        q_r   <= {q_r[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/flb_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// flb_ctrl: sequencing state machine
// Steps an item through checks, flow scan, backend load search and commit.
// ---------------------------------------------------------------------------
module flb_ctrl
  import flb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire flb_sts_t sts,
  output flb_cmd_t      cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CHECK  = 9'b000000010,
    S_SCAN   = 9'b000000100,
    S_BTEST  = 9'b000001000,
    S_DIVS   = 9'b000010000,
    S_DIVW   = 9'b000100000,
    S_PICK   = 9'b001000000,
    S_COMMIT = 9'b010000000,
    S_FIN    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.udp ? S_SCAN : S_FIN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) state_nxt = S_COMMIT;
        else if (sts.miss) state_nxt = S_BTEST;
      end
      S_BTEST: state_nxt = sts.b_more ? S_DIVS : S_PICK;
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVW;
      end
      S_DIVW: begin
        if (sts.div_done) begin
          cmd.bstep = 1'b1;
          state_nxt = S_BTEST;
        end
      end
      S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = sts.have ? S_COMMIT : S_FIN;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        // result register free or emptied this cycle
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/flb_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// flb_dpath: balancer datapath
// Item registers, header checks, flow table, backend state, load search.
// ---------------------------------------------------------------------------
module flb_dpath
  import flb_pkg::*;
#(
  parameter int MAX_BACKENDS = DEF_MAX_BACKENDS,
  parameter int FLOW_ENTRIES = DEF_FLOW_ENTRIES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire flb_cmd_t    cmd,
  output flb_sts_t         sts,
  input  wire logic        cfg_valid,
  input  wire logic [3:0]  cfg_data,
  input  wire logic        in_action,
  input  wire logic [15:0] in_frame_length,
  input  wire logic [15:0] in_ether_type,
  input  wire logic [3:0]  in_header_words,
  input  wire logic [7:0]  in_ip_protocol,
  input  wire logic [15:0] in_udp_length,
  input  wire logic [31:0] in_source_address,
  input  wire logic [31:0] in_dest_address,
  input  wire logic [15:0] in_source_port,
  input  wire logic [15:0] in_dest_port,
  input  wire logic [2:0]  in_backend_slot,
  input  wire logic [31:0] in_backend_ip,
  output logic [1:0]       out_verdict,
  output logic [2:0]       out_chosen_backend,
  output logic [31:0]      out_tunnel_dest,
  output logic             out_flow_is_new,
  output logic             out_flow_recorded
);

  // the 4-bit backend limit cannot exceed 15, so further backends are never reachable
  localparam int NB     = (MAX_BACKENDS < 15) ? MAX_BACKENDS : 15;
  localparam int SLOT_W = (NB > 1) ? $clog2(NB) : 1;
  localparam int AW     = $clog2(FLOW_ENTRIES);
  localparam int FILL_W = $clog2(FLOW_ENTRIES + 1);
  localparam int KEY_W  = 96;
  localparam int ENT_W  = KEY_W + SLOT_W;

  // item registers
  logic          action_r;
  logic [15:0]   flen_r, etype_r, ulen_r;
  logic [3:0]    hwords_r;
  logic [7:0]    proto_r;
  logic [KEY_W-1:0] key_r;
  logic [2:0]    bslot_r;
  logic [31:0]   bip_r;

  logic [3:0]    bcount_r;

  logic [31:0]   baddr_r [NB];
  logic [31:0]   fcnt_r  [NB];
  logic [31:0]   pcnt_r  [NB];

  logic [ENT_W-1:0]  flow_mem [FLOW_ENTRIES];
  logic [ENT_W-1:0]  rdata_r;
  logic [FILL_W-1:0] fill_r, ptr_r;
  logic              rd_vld_r;

  logic [3:0]    bidx_r, cidx_r;
  logic [31:0]   min_r;
  logic          have_r, new_r;

  logic [1:0]    res_verdict_r;
  logic [2:0]    res_chosen_r;
  logic [31:0]   res_dest_r;
  logic          res_new_r, res_rec_r;

  logic [1:0]    ov_r;
  logic [2:0]    oc_r;
  logic [31:0]   od_r;
  logic          on_r, orec_r;

  // header checks
  logic [16:0] hbytes, flen17;
  logic        pass_c, drop_c, setup_c;
  logic [3:0]  lim;
  logic        match, rd_go, room;
  logic [SLOT_W-1:0] bi;
  logic [31:0] div_q, load;
  logic        div_done;

  assign hbytes  = {11'd0, hwords_r, 2'b00};
  assign flen17  = {1'b0, flen_r};
  assign setup_c = (action_r == ACTION_SETUP);
  assign pass_c  = (flen17 < ETH_BYTES) || (etype_r != ETYPE_IPV4) ||
                   (flen17 < ETH_BYTES + IP_MIN_BYTES) || (hbytes < IP_MIN_BYTES) ||
                   (ETH_BYTES + hbytes > flen17) || (proto_r != PROTO_UDP);
  assign drop_c  = (ETH_BYTES + hbytes + UDP_BYTES > flen17) ||
                   ({1'b0, ulen_r} < UDP_BYTES);

  assign lim   = (bcount_r < 4'(NB)) ? bcount_r : 4'(NB);
  assign bi    = bidx_r[SLOT_W-1:0];
  assign match = rd_vld_r && (rdata_r[ENT_W-1:SLOT_W] == key_r);
  assign rd_go = (ptr_r < fill_r);
  assign room  = (fill_r < FILL_W'(FLOW_ENTRIES));
  assign load  = (fcnt_r[bi] == 32'd0) ? 32'd0 : div_q;

  assign sts.udp      = !setup_c && !pass_c && !drop_c;
  assign sts.hit      = match;
  assign sts.miss     = !rd_vld_r && !rd_go;
  assign sts.b_more   = (bidx_r < lim);
  assign sts.div_done = div_done;
  assign sts.have     = have_r;

  flb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (pcnt_r[bi]),
    .divisor  (fcnt_r[bi]),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      flen_r   <= in_frame_length;
      etype_r  <= in_ether_type;
      hwords_r <= in_header_words;
      proto_r  <= in_ip_protocol;
      ulen_r   <= in_udp_length;
      key_r    <= {in_source_address, in_dest_address, in_source_port, in_dest_port};
      bslot_r  <= in_backend_slot;
      bip_r    <= in_backend_ip;
    end
  end

  // flow table: entries fill in order and are never removed,
  // so the fill count doubles as the valid range and the free slot
  always_ff @(posedge clk) begin
    if (cmd.commit && new_r && room)
      flow_mem[fill_r[AW-1:0]] <= {key_r, cidx_r[SLOT_W-1:0]};
    if (cmd.scan && rd_go)
      rdata_r <= flow_mem[ptr_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcount_r <= '0;
      fill_r   <= '0;
      ptr_r    <= '0;
      rd_vld_r <= 1'b0;
      bidx_r   <= '0;
      cidx_r   <= '0;
      min_r    <= '1;
      have_r   <= 1'b0;
      new_r    <= 1'b0;
      ov_r     <= '0;
      oc_r     <= '0;
      od_r     <= '0;
      on_r     <= 1'b0;
      orec_r   <= 1'b0;
      for (int i = 0; i < NB; i++) begin
        baddr_r[i] <= '0;
        fcnt_r[i]  <= '0;
        pcnt_r[i]  <= '0;
      end
    end else begin
      if (cfg_valid) bcount_r <= cfg_data;

      if (cmd.check) begin
        ptr_r         <= '0;
        rd_vld_r      <= 1'b0;
        bidx_r        <= '0;
        min_r         <= '1;
        have_r        <= 1'b0;
        res_verdict_r <= (!setup_c && !pass_c) ? VERDICT_DROP : VERDICT_PASS;
        res_chosen_r  <= '0;
        res_dest_r    <= '0;
        res_new_r     <= 1'b0;
        res_rec_r     <= 1'b0;
        if (setup_c && ({1'b0, bslot_r} < 4'(NB))) begin
          baddr_r[bslot_r[SLOT_W-1:0]] <= bip_r;
          fcnt_r[bslot_r[SLOT_W-1:0]]  <= '0;
          pcnt_r[bslot_r[SLOT_W-1:0]]  <= '0;
        end
      end

      if (cmd.scan) begin
        rd_vld_r <= rd_go;
        if (rd_go) ptr_r <= ptr_r + 1'b1;
        if (match) begin
          bidx_r <= 4'(rdata_r[SLOT_W-1:0]);
          new_r  <= 1'b0;
        end
      end

      if (cmd.bstep) begin
        if (load < min_r) begin
          min_r  <= load;
          cidx_r <= bidx_r;
          have_r <= 1'b1;
        end
        bidx_r <= bidx_r + 1'b1;
      end

      if (cmd.pick) begin
        bidx_r <= cidx_r;
        new_r  <= 1'b1;
        if (!have_r) begin
          res_verdict_r <= VERDICT_ABORT;
          res_new_r     <= 1'b1;
        end
      end

      // commit reads the backend via bidx, set either on a hit or by pick
      if (cmd.commit) begin
        res_verdict_r <= VERDICT_FORWARD;
        res_chosen_r  <= bidx_r[2:0];
        res_dest_r    <= baddr_r[bi];
        res_new_r     <= new_r;
        res_rec_r     <= new_r && room;
        if (pcnt_r[bi] != '1) pcnt_r[bi] <= pcnt_r[bi] + 1'b1;
        if (new_r) begin
          if (fcnt_r[bi] != '1) fcnt_r[bi] <= fcnt_r[bi] + 1'b1;
          if (room) fill_r <= fill_r + 1'b1;
        end
      end

      if (cmd.out_load) begin
        ov_r   <= res_verdict_r;
        oc_r   <= res_chosen_r;
        od_r   <= res_dest_r;
        on_r   <= res_new_r;
        orec_r <= res_rec_r;
      end
    end
  end

  assign out_verdict        = ov_r;
  assign out_chosen_backend = oc_r;
  assign out_tunnel_dest    = od_r;
  assign out_flow_is_new    = on_r;
  assign out_flow_recorded  = orec_r;

endmodule
`default_nettype wire

@@ sv/flow_affine_least_load_balancer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// flow_affine_least_load_balancer_core: flow-affine least-load UDP balancer
// Classifies frame headers and steers UDP flows to backends.
// ---------------------------------------------------------------------------
// in_*  : one item per transfer, a backend set-up or a frame's header fields;
//         in_ready is high only while the block is between items.
// out_* : one result per item, held in an output register until taken; the
//         next item is accepted while a result waits.
// cfg_* : writes the backend limit; always ready, write only while idle.
// Set-up, pass and drop items go from the checks straight to the result. A UDP
// frame scans the flow table one entry per cycle from its single read port
// until a known flow is found or the stored flows run out. An unknown flow
// then runs the serial divider once per considered backend, and an abort
// skips the commit. in_ready returns as out_valid rises: the block takes no
// new item until the result of the last one is loaded.
// A stalled receiver holds the result and the next item waits in FIN.
// Reset clears counters, addresses and the flow fill count.
// ---------------------------------------------------------------------------
module flow_affine_least_load_balancer_core
  import flb_pkg::*;
#(
  parameter int MAX_BACKENDS = DEF_MAX_BACKENDS,
  parameter int FLOW_ENTRIES = DEF_FLOW_ENTRIES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic [15:0] in_frame_length,
  input  wire logic [15:0] in_ether_type,
  input  wire logic [3:0]  in_header_words,
  input  wire logic [7:0]  in_ip_protocol,
  input  wire logic [15:0] in_udp_length,
  input  wire logic [31:0] in_source_address,
  input  wire logic [31:0] in_dest_address,
  input  wire logic [15:0] in_source_port,
  input  wire logic [15:0] in_dest_port,
  input  wire logic [2:0]  in_backend_slot,
  input  wire logic [31:0] in_backend_ip,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_verdict,
  output logic [2:0]       out_chosen_backend,
  output logic [31:0]      out_tunnel_dest,
  output logic             out_flow_is_new,
  output logic             out_flow_recorded
);

  flb_cmd_t cmd;
  flb_sts_t sts;

  assign cfg_ready = 1'b1;

  flb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  flb_dpath #(
    .MAX_BACKENDS (MAX_BACKENDS),
    .FLOW_ENTRIES (FLOW_ENTRIES)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_valid          (cfg_valid),
    .cfg_data           (cfg_data),
    .in_action          (in_action),
    .in_frame_length    (in_frame_length),
    .in_ether_type      (in_ether_type),
    .in_header_words    (in_header_words),
    .in_ip_protocol     (in_ip_protocol),
    .in_udp_length      (in_udp_length),
    .in_source_address  (in_source_address),
    .in_dest_address    (in_dest_address),
    .in_source_port     (in_source_port),
    .in_dest_port       (in_dest_port),
    .in_backend_slot    (in_backend_slot),
    .in_backend_ip      (in_backend_ip),
    .out_verdict        (out_verdict),
    .out_chosen_backend (out_chosen_backend),
    .out_tunnel_dest    (out_tunnel_dest),
    .out_flow_is_new    (out_flow_is_new),
    .out_flow_recorded  (out_flow_recorded)
  );

endmodule
`default_nettype wire

@@ bench/flb_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flb_checker: steering predictor and result scoreboard
// Watches the config, item and result channels, keeps its own copy of the
// flow table and backend counters, and compares each result transfer.
// ---------------------------------------------------------------------------
module flb_checker
  import flb_pkg::*;
#(
  parameter int MAXB  = DEF_MAX_BACKENDS,
  parameter int FLOWS = DEF_FLOW_ENTRIES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_action,
  input  logic [15:0] in_frame_length,
  input  logic [15:0] in_ether_type,
  input  logic [3:0]  in_header_words,
  input  logic [7:0]  in_ip_protocol,
  input  logic [15:0] in_udp_length,
  input  logic [31:0] in_source_address,
  input  logic [31:0] in_dest_address,
  input  logic [15:0] in_source_port,
  input  logic [15:0] in_dest_port,
  input  logic [2:0]  in_backend_slot,
  input  logic [31:0] in_backend_ip,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_verdict,
  input  logic [2:0]  out_chosen_backend,
  input  logic [31:0] out_tunnel_dest,
  input  logic        out_flow_is_new,
  input  logic        out_flow_recorded,
  output int          errors,
  output int          pending,
  output int          results,
  output int          flows_logged
);

  typedef struct packed {
    logic [1:0]  verdict;
    logic [2:0]  backend;
    logic [31:0] dest;
    logic        is_new;
    logic        recorded;
  } steer_t;

  steer_t steer_q[$];

  logic        fl_used [FLOWS];
  logic [31:0] fl_src  [FLOWS];
  logic [31:0] fl_dst  [FLOWS];
  logic [15:0] fl_sp   [FLOWS];
  logic [15:0] fl_dp   [FLOWS];
  logic [2:0]  fl_slot [FLOWS];
  logic [31:0] be_addr  [MAXB];
  logic [31:0] be_flows [MAXB];
  logic [31:0] be_pkts  [MAXB];
  logic [3:0]  be_limit;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic steer_t steer_frame();
    steer_t r;
    int unsigned flen, hb, free_at, idx, slot;
    logic [31:0] load, best_load;
    logic found, have;
    r = '0;
    flen = in_frame_length;
    hb = in_header_words * 4;
    if (in_action == ACTION_SETUP) begin
      if (in_backend_slot < MAXB) begin
        be_addr[in_backend_slot]  = in_backend_ip;
        be_flows[in_backend_slot] = '0;
        be_pkts[in_backend_slot]  = '0;
      end
      return r;
    end
    if (flen < ETH_BYTES || in_ether_type != ETYPE_IPV4 || flen < ETH_BYTES + IP_MIN_BYTES ||
        hb < IP_MIN_BYTES || ETH_BYTES + hb > flen || in_ip_protocol != PROTO_UDP)
      return r;
    if (ETH_BYTES + hb + UDP_BYTES > flen || in_udp_length < UDP_BYTES) begin
      r.verdict = VERDICT_DROP;
      return r;
    end
    found = 1'b0;
    free_at = FLOWS;
    slot = 0;
    for (idx = 0; idx < FLOWS; idx++) begin
      if (fl_used[idx]) begin
        if (!found && fl_src[idx] == in_source_address && fl_dst[idx] == in_dest_address &&
            fl_sp[idx] == in_source_port && fl_dp[idx] == in_dest_port) begin
          found = 1'b1;
          slot = fl_slot[idx];
        end
      end else if (free_at == FLOWS) begin
        free_at = idx;
      end
    end
    if (found) begin
      be_pkts[slot] = sat_inc(be_pkts[slot]);
      r.verdict = VERDICT_FORWARD;
      r.backend = 3'(slot);
      r.dest = be_addr[slot];
      return r;
    end
    // least packets per flow, idle backend counts as zero load
    have = 1'b0;
    best_load = 32'hFFFF_FFFF;
    for (idx = 0; idx < be_limit && idx < MAXB; idx++) begin
      load = (be_flows[idx] == 0) ? 32'd0 : be_pkts[idx] / be_flows[idx];
      if (load < best_load) begin
        best_load = load;
        slot = idx;
        have = 1'b1;
      end
    end
    r.is_new = 1'b1;
    if (!have) begin
      r.verdict = VERDICT_ABORT;
      return r;
    end
    be_pkts[slot]  = sat_inc(be_pkts[slot]);
    be_flows[slot] = sat_inc(be_flows[slot]);
    r.verdict = VERDICT_FORWARD;
    r.backend = 3'(slot);
    r.dest = be_addr[slot];
    if (free_at < FLOWS) begin
      fl_used[free_at] = 1'b1;
      fl_src[free_at]  = in_source_address;
      fl_dst[free_at]  = in_dest_address;
      fl_sp[free_at]   = in_source_port;
      fl_dp[free_at]   = in_dest_port;
      fl_slot[free_at] = 3'(slot);
      r.recorded = 1'b1;
    end
    return r;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    results = 0;
    flows_logged = 0;
  end

  always @(posedge clk) begin
    steer_t want, got;
    if (!rst_n) begin
      for (int i = 0; i < FLOWS; i++) fl_used[i] = 1'b0;
      for (int i = 0; i < MAXB; i++) begin
        be_addr[i] = '0;
        be_flows[i] = '0;
        be_pkts[i] = '0;
      end
      be_limit = '0;
      steer_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) be_limit = cfg_data;
      if (in_valid && in_ready) begin
        want = steer_frame();
        if (want.recorded) flows_logged++;
        steer_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        results++;
        got = '{out_verdict, out_chosen_backend, out_tunnel_dest, out_flow_is_new,
                out_flow_recorded};
        if (steer_q.size() == 0) begin
          $error("result transfer with nothing outstanding");
          errors++;
        end else begin
          want = steer_q.pop_front();
          if (got.verdict != want.verdict) begin
            $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
            errors++;
          end
          if (got.backend != want.backend) begin
            $error("chosen_backend: expected %0d, got %0d", want.backend, got.backend);
            errors++;
          end
          if (got.dest != want.dest) begin
            $error("tunnel_dest: expected %h, got %h", want.dest, got.dest);
            errors++;
          end
          if (got.is_new != want.is_new) begin
            $error("flow_is_new: expected %0d, got %0d", want.is_new, got.is_new);
            errors++;
          end
          if (got.recorded != want.recorded) begin
            $error("flow_recorded: expected %0d, got %0d", want.recorded, got.recorded);
            errors++;
          end
        end
      end
    end
    pending = steer_q.size();
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: least-load balancer core testbench
// Directed header corner cases, then phases of random flows under several
// backend counts, filling the flow table, with random stalls on both sides.
// ---------------------------------------------------------------------------
module tb;
  import flb_pkg::*;

  typedef struct {
    bit        action;
    bit [15:0] flen;
    bit [15:0] etype;
    bit [3:0]  hw;
    bit [7:0]  proto;
    bit [15:0] ulen;
    bit [31:0] src;
    bit [31:0] dst;
    bit [15:0] sp;
    bit [15:0] dp;
    bit [2:0]  slot;
    bit [31:0] ip;
  } hdr_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [3:0] cfg_data = '0;
  logic in_valid = 1'b0, in_ready;
  logic in_action = 1'b0;
  logic [15:0] in_frame_length = '0, in_ether_type = '0, in_udp_length = '0;
  logic [3:0] in_header_words = '0;
  logic [7:0] in_ip_protocol = '0;
  logic [31:0] in_source_address = '0, in_dest_address = '0, in_backend_ip = '0;
  logic [15:0] in_source_port = '0, in_dest_port = '0;
  logic [2:0] in_backend_slot = '0;
  logic out_valid, out_ready = 1'b0;
  logic [1:0] out_verdict;
  logic [2:0] out_chosen_backend;
  logic [31:0] out_tunnel_dest;
  logic out_flow_is_new, out_flow_recorded;
  int errors, pending, results, flows_logged;

  bit steady = 1'b0;
  int stall_left = 0;
  int sent = 0;
  hdr_t seen_flows[$];

  always #10 clk = ~clk;

  flow_affine_least_load_balancer_core u_dut (.*);

  flb_checker u_chk (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = 1'b1;
      if (!steady && $urandom_range(0, 3) == 0) stall_left = gap_len();
    end
  end

  function automatic hdr_t noise();
    hdr_t h;
    h.action = 1'($urandom);
    h.flen = 16'($urandom);
    h.etype = 16'($urandom);
    h.hw = 4'($urandom);
    h.proto = 8'($urandom);
    h.ulen = 16'($urandom);
    h.src = $urandom;
    h.dst = $urandom;
    h.sp = 16'($urandom);
    h.dp = 16'($urandom);
    h.slot = 3'($urandom);
    h.ip = $urandom;
    return h;
  endfunction

  // well-formed UDP frame around the given 4-tuple
  function automatic hdr_t udp_frame(hdr_t h);
    int lo;
    h.action = 1'b0;
    h.etype = ETYPE_IPV4;
    h.proto = PROTO_UDP;
    h.hw = 4'($urandom_range(5, 15));
    lo = 14 + 4 * h.hw + 8;
    h.flen = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(lo, 65535)) :
                                           16'($urandom_range(lo, lo + 64));
    h.ulen = 16'($urandom_range(8, 65535));
    return h;
  endfunction

  // entered and left at a falling edge
  task automatic send(hdr_t h);
    int n;
    n = steady ? 0 : gap_len();
    if (n > 0) begin
      in_valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    in_action = h.action;
    in_frame_length = h.flen;
    in_ether_type = h.etype;
    in_header_words = h.hw;
    in_ip_protocol = h.proto;
    in_udp_length = h.ulen;
    in_source_address = h.src;
    in_dest_address = h.dst;
    in_source_port = h.sp;
    in_dest_port = h.dp;
    in_backend_slot = h.slot;
    in_backend_ip = h.ip;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sent++;
    @(negedge clk);
  endtask

  task automatic set_backend_count(logic [3:0] cnt);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (40) @(negedge clk);
    cfg_data = cnt;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_item(bit fresh_only);
    hdr_t h;
    int r;
    int lo;
    h = noise();
    r = fresh_only ? 99 : $urandom_range(0, 99);
    if (r < 5) begin
      h.action = ACTION_SETUP;
    end else if (r < 12) begin
      h.action = 1'b0;
    end else if (r < 20) begin
      h = udp_frame(h);
      lo = 14 + 4 * h.hw;
      if ($urandom_range(0, 1)) h.flen = 16'($urandom_range(lo, lo + 7));
      else h.ulen = 16'($urandom_range(0, 7));
    end else if (r < 32 && seen_flows.size() > 0) begin
      h = seen_flows[$urandom_range(0, seen_flows.size() - 1)];
      h = udp_frame(h);
    end else begin
      h = udp_frame(h);
      seen_flows.push_back(h);
    end
    send(h);
  endtask

  task automatic directed();
    hdr_t h;
    hdr_t zero_flow;
    // no backend configured yet: unknown flow aborts
    h = noise();
    h = udp_frame(h);
    send(h);
    set_backend_count(4'd2);
    h = noise(); h.action = ACTION_SETUP; h.slot = 3'd0; h.ip = 32'hFFFF_FFFF; send(h);
    h = noise(); h.action = ACTION_SETUP; h.slot = 3'd1; h.ip = 32'h0; send(h);
    h = noise(); h.action = ACTION_SETUP; h.slot = 3'd7; h.ip = 32'h1234_5678; send(h);
    // checks that let the frame pass
    h = udp_frame(noise()); h.etype = 16'hFFFF; send(h);
    h = udp_frame(noise()); h.proto = 8'hFF; send(h);
    h = udp_frame(noise()); h.flen = 16'd0; send(h);
    h = udp_frame(noise()); h.hw = 4'd5; h.flen = 16'd33; send(h);
    h = udp_frame(noise()); h.hw = 4'd4; h.flen = 16'd200; send(h);
    h = udp_frame(noise()); h.hw = 4'd0; send(h);
    h = udp_frame(noise()); h.hw = 4'd15; h.flen = 16'd73; send(h);
    // drops: truncated UDP header, short UDP length
    h = udp_frame(noise()); h.hw = 4'd15; h.flen = 16'd74; send(h);
    h = udp_frame(noise()); h.hw = 4'd15; h.flen = 16'd81; send(h);
    h = udp_frame(noise()); h.ulen = 16'd7; send(h);
    h = udp_frame(noise()); h.ulen = 16'd0; send(h);
    // smallest good frame, zero tuple: idle backends tie, lowest wins
    zero_flow = noise();
    zero_flow.src = '0; zero_flow.dst = '0; zero_flow.sp = '0; zero_flow.dp = '0;
    h = udp_frame(zero_flow); h.hw = 4'd5; h.flen = 16'd42; h.ulen = 16'd8; send(h);
    h = udp_frame(noise());
    h.src = '1; h.dst = '1; h.sp = '1; h.dp = '1;
    h.hw = 4'd15; h.flen = 16'hFFFF; h.ulen = 16'hFFFF;
    send(h);
    h = udp_frame(zero_flow); send(h);
    // re-setup keeps the flow entry pointing at the slot
    h = noise(); h.action = ACTION_SETUP; h.slot = 3'd0; h.ip = 32'hA5A5_0001; send(h);
    h = udp_frame(zero_flow); send(h);
    seen_flows.push_back(zero_flow);
  endtask

  initial begin
    logic [3:0] counts[7];
    counts = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd3, 4'd8, 4'd2};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    directed();
    foreach (counts[p]) begin
      set_backend_count(counts[p]);
      steady = (p == 2);
      repeat (counts[p] == 0 ? 60 : 200) random_item(1'b0);
    end
    // keep adding fresh flows until the table has been full for a while
    steady = 1'b0;
    set_backend_count(4'd1);
    while (flows_logged < DEF_FLOW_ENTRIES) random_item(1'b1);
    repeat (40) random_item(1'b0);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (50) @(posedge clk);
    $display("Sent %0d items, checked %0d results; %0d flows stored, table filled.",
             sent, results, flows_logged);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #250ms;
    $display("Run timed out.");
    $display("== FAIL ==");
    $finish;
  end

endmodule
